FILE: hw/rtl/z85_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_pkg
// Shared types, constants and the Z85 symbol lookup for the Z85 encoder.
// ----------------------------------------------------------------------------
package z85_pkg;

    // Base and group shape
    localparam int Z85_BASE      = 85;
    localparam int Z85_DIGITS    = 5;
    localparam int GROUP_W       = 32;
    localparam int HELD_W        = 24;
    localparam int Z85_QUEUE_DEPTH = 2;

    // Fixed-point reciprocal of 85^5: frac = value * RECIP / 2^FRAC_W
    localparam int FRAC_W        = 66;
    localparam int RECIP_W       = 34;
    localparam int RECIP_LO_W    = 17;
    localparam int RECIP_HI_W    = RECIP_W - RECIP_LO_W;
    localparam int PROD_HI_W     = GROUP_W + RECIP_HI_W;
    localparam int PROD_LO_W     = GROUP_W + RECIP_LO_W;
    localparam int DIGIT_W       = 7;
    localparam int SCALED_W      = FRAC_W + DIGIT_W;

    localparam logic [71:0] Z85_POW5   = 72'd4437053125;
    localparam logic [71:0] RECIP_FULL =
        ((72'd1 << FRAC_W) + Z85_POW5 - 72'd1) / Z85_POW5;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // Payload of one input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    // Payload of one output transfer
    typedef struct packed {
        logic [6:0] out_char;
        logic       group_last;
    } t_out_item;

    // Group handed from the front end to the queue
    typedef struct packed {
        logic               valid;
        logic [GROUP_W-1:0] value;
    } t_grp_push;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Map one base-85 digit to its Z85 symbol
    function automatic logic [6:0] z85_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] c;
        c = 7'("#");
        if (d < 7'd10) begin
            c = 7'(7'd48 + d);
        end else if (d < 7'd36) begin
            c = 7'(7'd87 + d);
        end else if (d < 7'd62) begin
            c = 7'(7'd29 + d);
        end else begin
            case (d)
                7'd62:   c = 7'(".");
                7'd63:   c = 7'("-");
                7'd64:   c = 7'(":");
                7'd65:   c = 7'("+");
                7'd66:   c = 7'("=");
                7'd67:   c = 7'("^");
                7'd68:   c = 7'("!");
                7'd69:   c = 7'("/");
                7'd70:   c = 7'("*");
                7'd71:   c = 7'("?");
                7'd72:   c = 7'("&");
                7'd73:   c = 7'("<");
                7'd74:   c = 7'(">");
                7'd75:   c = 7'("(");
                7'd76:   c = 7'(")");
                7'd77:   c = 7'("[");
                7'd78:   c = 7'("]");
                7'd79:   c = 7'("{");
                7'd80:   c = 7'("}");
                7'd81:   c = 7'("@");
                7'd82:   c = 7'("%");
                7'd83:   c = 7'("$");
                default: c = 7'("#");
            endcase
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/z85_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_front
// Input side: collects bytes into 32-bit groups, pads a short final group
// with zero bytes and pushes each finished group into the queue.
// ----------------------------------------------------------------------------
module z85_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  z85_pkg::t_in_item   i_in_data,
    input  z85_pkg::t_q_status  i_q_stat,
    output z85_pkg::t_grp_push  o_push
);
    import z85_pkg::*;

    logic [HELD_W-1:0]  r_held, n_held;
    logic [1:0]         r_cnt, n_cnt;
    logic               accept;
    logic               close_grp;
    logic [GROUP_W-1:0] joined;
    logic [GROUP_W-1:0] padded;

    // Hold off the sender whenever the queue has no free slot
    assign o_in_stall = i_q_stat.full;
    assign accept     = i_in_valid && !i_q_stat.full;
    assign close_grp  = i_in_data.end_of_data || (r_cnt == 2'd3);
    assign joined     = {r_held, i_in_data.data_byte};

    // Shift the real bytes up and fill the low end with zero bytes
    always_comb begin
        case (r_cnt)
            2'd0:    padded = {joined[7:0], 24'd0};
            2'd1:    padded = {joined[15:0], 16'd0};
            2'd2:    padded = {joined[23:0], 8'd0};
            default: padded = joined;
        endcase
    end

    assign o_push.valid = accept && close_grp;
    assign o_push.value = padded;

    // Advance the open group
    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        if (accept) begin
            if (close_grp) begin
                n_held = '0;
                n_cnt  = '0;
            end else begin
                n_held = {r_held[HELD_W-9:0], i_in_data.data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_cnt  <= '0;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/z85_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_queue
// Short register queue of packed groups between the front and back ends.
// ----------------------------------------------------------------------------
module z85_queue #(
    parameter int DEPTH = z85_pkg::Z85_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  z85_pkg::t_grp_push            i_push,
    input  logic                          i_pop,
    output logic [z85_pkg::GROUP_W-1:0]   o_q_data,
    output z85_pkg::t_q_status            o_q_stat
);
    import z85_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [GROUP_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_q_stat.full  = (r_count == FULL_CNT);
    assign o_q_stat.empty = (r_count == '0);
    assign o_q_data       = r_slot[r_rd_ptr];

    assign do_push = i_push.valid && !o_q_stat.full;
    assign do_pop  = i_pop && !o_q_stat.empty;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed group
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.value;
        end
    end

endmodule

FILE: hw/rtl/z85_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_back
// Output side: scales each group by a fixed-point reciprocal of 85^5, then
// peels one base-85 digit a cycle while the output is not stalled, most
// significant first, into the output register.
// ----------------------------------------------------------------------------
module z85_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [z85_pkg::GROUP_W-1:0]   i_q_data,
    input  z85_pkg::t_q_status            i_q_stat,
    output logic                          o_q_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output z85_pkg::t_out_item            o_out_data
);
    import z85_pkg::*;

    localparam int DCNT_W = $clog2(Z85_DIGITS);
    localparam logic [DCNT_W-1:0] LAST_DIGIT = DCNT_W'(Z85_DIGITS - 1);

    // Product stage
    logic                 r_prod_vld, n_prod_vld;
    logic [PROD_HI_W-1:0] r_p_hi;
    logic [PROD_LO_W-1:0] r_p_lo;
    // Digit engine
    logic                 r_eng_vld, n_eng_vld;
    logic [FRAC_W-1:0]    r_frac, n_frac;
    logic [DCNT_W-1:0]    r_dcnt, n_dcnt;
    // Output register
    logic                 r_out_vld, n_out_vld;
    t_out_item            r_out, n_out;

    logic                 out_open;
    logic                 emit;
    logic                 eng_free;
    logic                 prod_free;
    logic [FRAC_W-1:0]    scaled_sum;
    logic [SCALED_W-1:0]  times_base;
    logic [DIGIT_W-1:0]   digit;

    assign out_open  = !r_out_vld || !i_out_stall;
    assign emit      = r_eng_vld && out_open;
    assign eng_free  = !r_eng_vld || (emit && (r_dcnt == LAST_DIGIT));
    assign prod_free = !r_prod_vld || eng_free;
    assign o_q_pop   = prod_free && !i_q_stat.empty;

    // Join the two partial products
    assign scaled_sum = FRAC_W'({r_p_hi, {RECIP_LO_W{1'b0}}}) + FRAC_W'(r_p_lo);

    // Next digit is the integer part of frac * 85
    assign times_base = SCALED_W'(r_frac) * SCALED_W'(Z85_BASE);
    assign digit      = times_base[SCALED_W-1:FRAC_W];

    // Advance the pipeline
    always_comb begin
        n_prod_vld = r_prod_vld;
        n_eng_vld  = r_eng_vld;
        n_frac     = r_frac;
        n_dcnt     = r_dcnt;
        n_out_vld  = r_out_vld;
        n_out      = r_out;

        if (prod_free) begin
            n_prod_vld = !i_q_stat.empty;
        end

        if (emit) begin
            n_frac = times_base[FRAC_W-1:0];
            n_dcnt = r_dcnt + DCNT_W'(1);
        end
        if (eng_free) begin
            n_eng_vld = r_prod_vld;
            n_frac    = scaled_sum;
            n_dcnt    = '0;
        end

        if (emit) begin
            n_out_vld        = 1'b1;
            n_out.out_char   = z85_char(digit);
            n_out.group_last = (r_dcnt == LAST_DIGIT);
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_eng_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_dcnt     <= '0;
        end else begin
            r_prod_vld <= n_prod_vld;
            r_eng_vld  <= n_eng_vld;
            r_out_vld  <= n_out_vld;
            r_dcnt     <= n_dcnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_frac <= n_frac;
        r_out  <= n_out;
        if (o_q_pop) begin
            r_p_hi <= PROD_HI_W'(i_q_data) * PROD_HI_W'(RECIP[RECIP_W-1:RECIP_LO_W]);
            r_p_lo <= PROD_LO_W'(i_q_data) * PROD_LO_W'(RECIP[RECIP_LO_W-1:0]);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/z85_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_encoder
// Z85 byte-stream encoder: four bytes in, five alphabet characters out.
// ----------------------------------------------------------------------------
// The encoder takes one byte per transfer, at most one per cycle, and packs
// every four into a big-endian 32-bit group; a byte flagged end_of_data
// closes the group, zero-padded if short. Each group leaves as five
// characters, the fifth flagged group_last. The stream is paced by the digit
// engine in the back end, which produces one base-85 digit per cycle while
// the output is not stalled. A closed group passes through the queue slot,
// the reciprocal multiply on pop, the partial-product add and the digit step
// before it reaches the output register. A queue of QUEUE_DEPTH groups sits
// between the byte packer and the digit engine; the input stalls only while
// that queue is full.
module z85_encoder #(
    parameter int QUEUE_DEPTH = z85_pkg::Z85_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  z85_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output z85_pkg::t_out_item  o_out_data
);
    import z85_pkg::*;

    t_grp_push          grp_push;
    t_q_status          q_stat;
    logic [GROUP_W-1:0] q_data;
    logic               q_pop;

    // Byte packing
    z85_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (grp_push)
    );

    // Group queue
    z85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (grp_push),
        .i_pop    (q_pop),
        .o_q_data (q_data),
        .o_q_stat (q_stat)
    );

    // Digit generation
    z85_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_data),
        .i_q_stat    (q_stat),
        .o_q_pop     (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/z85_encoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z85_encoder_checker
// Port-level checks for the Z85 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module z85_encoder_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  z85_pkg::t_in_item   i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  z85_pkg::t_out_item  o_out_data
);
    import z85_pkg::*;

    // No output transfer is offered right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A stalled output transfer stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // A stalled output payload holds
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed under stall");

    // Every character comes from the printable Z85 range
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.out_char >= 7'd33) && (o_out_data.out_char <= 7'd125))
        else $error("output character outside the Z85 range");

    // A stalled input transfer stays offered with the same payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input transfer changed under stall");

endmodule

bind z85_encoder z85_encoder_checker u_z85_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Z85 byte-stream encoder.
// ----------------------------------------------------------------------------
// Bytes go in through the valid/stall input channel. A bench-side model of
// the byte packer and the base-85 digit split predicts the five characters of
// every closed group, and each output transfer is checked against the oldest
// prediction. A short table covers zero and all-ones groups, a known vector,
// and short final groups. A long random stream of mostly full groups follows,
// with random final-byte marks. Both sides idle at random, with one quiet
// stretch; the output drains after the table and again in the random stream.
// ----------------------------------------------------------------------------
module tb;
    import z85_pkg::*;

    localparam int    N_ITEMS        = 370;
    localparam int    STALL_PCT      = 6;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    TAIL_CYCLES    = 20;
    localparam string Z85_SYMBOLS    =
        {"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
         ".-:+=^!/*?&<>()[]{}@%$#"};

    // One row of the directed table; typed rows carry their five characters
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_data;
        logic        typed;
        logic [39:0] chars;
    } t_dir_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    // Bench copy of the open group
    logic [23:0] held_val = '0;
    logic [1:0]  held_cnt = '0;

    t_out_item   char_q[$];
    t_dir_row    dir_table [0:22];
    int          n_errors    = 0;
    int          n_sent      = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;

    z85_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Pack one byte; on a closed group return its five characters
    function automatic bit pack_and_split(input t_in_item it, output t_out_item grp_chars [5]);
        logic [31:0] grp;
        int unsigned v;
        int unsigned d [5];
        if (!it.end_of_data && held_cnt < 2'd3) begin
            held_val = {held_val[15:0], it.data_byte};
            held_cnt = held_cnt + 2'd1;
            return 1'b0;
        end
        // zero-fill the low bytes of a short group
        grp = {held_val, it.data_byte};
        grp = grp << (8 * (3 - held_cnt));
        v = grp;
        for (int k = 4; k >= 0; k--) begin
            d[k] = v % 85;
            v = v / 85;
        end
        for (int k = 0; k < 5; k++) begin
            grp_chars[k].out_char   = 7'(Z85_SYMBOLS[d[k]]);
            grp_chars[k].group_last = (k == 4);
        end
        held_val = '0;
        held_cnt = '0;
        return 1'b1;
    endfunction

    // Drive one byte until transferred, then record what it should produce
    task automatic send_byte(input t_in_item it, input bit typed, input logic [39:0] chars);
        t_out_item grp_chars [5];
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        if (pack_and_split(it, grp_chars)) begin
            for (int k = 0; k < 5; k++) begin
                if (typed) begin
                    grp_chars[k].out_char = chars[38 - 8 * k -: 7];
                end
                char_q.push_back(grp_chars[k]);
            end
        end
    endtask

    // Hold the input until every predicted character has left
    task automatic drain_results();
        if (char_q.size() != 0) begin
            i_in_valid <= 1'b0;
            while (char_q.size() != 0) @(posedge i_clk);
        end
    endtask

    // Check each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item exp_c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (char_q.size() == 0) begin
                $display("%0t: unexpected output: expected none, actual char=%0d last=%0b",
                         $time, o_out_data.out_char, o_out_data.group_last);
                n_errors++;
            end else begin
                exp_c = char_q.pop_front();
                if (o_out_data.out_char !== exp_c.out_char) begin
                    $display("%0t: out_char mismatch: expected %0d, actual %0d",
                             $time, exp_c.out_char, o_out_data.out_char);
                    n_errors++;
                end
                if (o_out_data.group_last !== exp_c.group_last) begin
                    $display("%0t: group_last mismatch: expected %0b, actual %0b",
                             $time, exp_c.group_last, o_out_data.group_last);
                    n_errors++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end

    // Abort when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** z85_encoder: FAILED **");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int       r;
        int       glen;
        int       n_rand;

        dir_table = '{
            '{8'h00, 1'b0, 1'b0, 40'h0}, '{8'h00, 1'b0, 1'b0, 40'h0},
            '{8'h00, 1'b0, 1'b0, 40'h0}, '{8'h00, 1'b0, 1'b1, "00000"},
            '{8'hFF, 1'b0, 1'b0, 40'h0}, '{8'hFF, 1'b0, 1'b0, 40'h0},
            '{8'hFF, 1'b0, 1'b0, 40'h0}, '{8'hFF, 1'b0, 1'b1, "%nSc0"},
            '{8'h86, 1'b0, 1'b0, 40'h0}, '{8'h4F, 1'b0, 1'b0, 40'h0},
            '{8'hD2, 1'b0, 1'b0, 40'h0}, '{8'h6F, 1'b0, 1'b1, "Hello"},
            '{8'hB5, 1'b0, 1'b0, 40'h0}, '{8'h59, 1'b0, 1'b0, 40'h0},
            '{8'hF7, 1'b0, 1'b0, 40'h0}, '{8'h5B, 1'b1, 1'b1, "World"},
            '{8'hFF, 1'b1, 1'b0, 40'h0},
            '{8'h01, 1'b0, 1'b0, 40'h0}, '{8'h80, 1'b1, 1'b0, 40'h0},
            '{8'h12, 1'b0, 1'b0, 40'h0}, '{8'h34, 1'b0, 1'b0, 40'h0},
            '{8'h56, 1'b1, 1'b0, 40'h0},
            '{8'h00, 1'b1, 1'b1, "00000"}
        };

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_table[i]) begin
            it.data_byte   = dir_table[i].data_byte;
            it.end_of_data = dir_table[i].end_of_data;
            send_byte(it, dir_table[i].typed, dir_table[i].chars);
        end
        drain_results();

        // Random groups: mostly full, some closed early by the final-byte mark
        n_rand = 0;
        while (n_sent < N_ITEMS) begin
            r    = $urandom_range(99);
            glen = (r < 60) ? 4 : $urandom_range(1, 4);
            for (int b = 0; b < glen; b++) begin
                r = $urandom_range(9);
                it.data_byte   = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
                it.end_of_data = (glen != 4 || $urandom_range(4) == 0) && (b == glen - 1);
                calm = (n_rand >= 120 && n_rand < 220);
                send_byte(it, 1'b0, 40'h0);
                n_rand++;
            end
            if (n_rand >= 180 && n_rand < 184 && held_cnt == 2'd0) begin
                drain_results();
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Let the last groups leave, then watch for strays
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("** z85_encoder: PASSED **");
        end else begin
            $display("** z85_encoder: FAILED **");
        end
        $finish;
    end

endmodule
